// ===== sv/quadratic_root_solver_defines.svh =====
// Assertion helpers for the checker file.
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// Clocked on clk_i, off while rst_ni is low.
`define QRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked on clk_i, also checked during reset.
`define QRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/qrs_pkg.sv =====
package qrs_pkg;

  localparam int unsigned STATUS_W = 3;
  localparam int unsigned TOL_W    = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

  typedef enum logic [STATUS_W-1:0] {
    ST_TWO    = 3'd0,
    ST_LINEAR = 3'd1,
    ST_NONE   = 3'd2,
    ST_DEGEN  = 3'd3,
    ST_CHECK  = 3'd4
  } status_e;

endpackage

// ===== sv/quadratic_root_solver.sv =====
// Real roots of a*x^2 + b*x + c = 0 on signed fixed-point coefficients.
// Input channel: in_valid_i / in_stall_o with coeff_a_i, coeff_b_i, coeff_c_i;
// a request is taken at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with status_o, root_plus_o and
// root_minus_o; one result per request, in request order.
// cfg_we_i writes cfg_wdata_i into the residual tolerance; write it only
// while no request is in flight.
// Throughput: one request per cycle while in_stall_o is low. The pipeline depth
// is set by the square root (DATA_WIDTH+1 stages) and the dividers
// (DATA_WIDTH+FRAC_BITS+1 stages), one bit per stage.
// When the receiver stalls, the output register holds its result and the
// pipeline keeps moving until its last stage is full; then in_stall_o rises.
// Reset empties the pipeline and sets the tolerance to 66.
module quadratic_root_solver
  import qrs_pkg::*;
#(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [TOL_W-1:0]             cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] coeff_a_i,
  input  logic signed [DATA_WIDTH-1:0] coeff_b_i,
  input  logic signed [DATA_WIDTH-1:0] coeff_c_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [STATUS_W-1:0]          status_o,
  output logic signed [DATA_WIDTH-1:0] root_plus_o,
  output logic signed [DATA_WIDTH-1:0] root_minus_o
);

  localparam int W      = DATA_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int ROOT_W = W + 1;
  localparam int DISC_W = 2 * ROOT_W;
  localparam int NUM_W  = W + 1 + F;
  localparam int DEN_W  = W + 1;
  localparam int CW     = W + F + 2;
  localparam int MX     = 2 * W + F + 2;
  localparam int PW     = CW + W;
  localparam int VX     = 2 * W + 4;
  localparam int LO_W   = CW / 2;
  localparam int HI_W   = CW - LO_W;

  typedef struct packed {
    logic         an;
    logic [W-1:0] am;
    logic         bn;
    logic [W-1:0] bm;
    logic         cn;
    logic [W-1:0] cm;
    status_e      st;
  } coef_t;

  localparam int COEF_W = $bits(coef_t);

  function automatic logic [W-1:0] mag_of(logic [W-1:0] v);
    mag_of = v[W-1] ? (~v + W'(1)) : v;
  endfunction

  function automatic logic [W-1:0] sat_mag(logic neg, logic [NUM_W-1:0] q);
    logic [NUM_W-1:0] half;
    half = NUM_W'(1) << (W - 1);
    if (q >= half) begin
      sat_mag = neg ? half[W-1:0] : (half[W-1:0] - W'(1));
    end else begin
      sat_mag = q[W-1:0];
    end
  endfunction

  logic [TOL_W-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  logic en;
  logic out_ld;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v8b_q, v9_q;

  // stage 1: sign and magnitude
  coef_t c1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q.an <= coeff_a_i[W-1];
      c1_q.am <= mag_of(coeff_a_i);
      c1_q.bn <= coeff_b_i[W-1];
      c1_q.bm <= mag_of(coeff_b_i);
      c1_q.cn <= coeff_c_i[W-1];
      c1_q.cm <= mag_of(coeff_c_i);
      c1_q.st <= ST_TWO;
    end
  end

  // stage 2: b*b and a*c
  coef_t c2_q;
  logic [2*W-1:0] sq_q, ac_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_q <= c1_q;
      sq_q <= c1_q.bm * c1_q.bm;
      ac_q <= c1_q.am * c1_q.cm;
    end
  end

  // stage 3: discriminant and case
  coef_t c3_d, c3_q;
  logic [DISC_W-1:0] disc_d, disc_q;
  logic [DISC_W-1:0] sq_x, ac4_x;
  always_comb begin
    sq_x  = DISC_W'(sq_q);
    ac4_x = {ac_q, 2'b00};
    c3_d  = c2_q;
    disc_d = '0;
    priority if (c2_q.am == '0) begin
      c3_d.st = (c2_q.bm == '0) ? ST_DEGEN : ST_LINEAR;
    end else if (c2_q.an != c2_q.cn) begin
      disc_d = sq_x + ac4_x;
    end else if (sq_x < ac4_x) begin
      c3_d.st = ST_NONE;
    end else begin
      disc_d = sq_x - ac4_x;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      c3_q   <= c3_d;
      disc_q <= disc_d;
    end
  end

  logic               sq_v;
  logic [ROOT_W-1:0]  sq_root;
  logic [COEF_W-1:0]  sq_side;

  qrs_sqrt #(
    .ROOT_W(ROOT_W),
    .SIDE_W(COEF_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v3_q),
    .rad_i  (disc_q),
    .side_i (c3_q),
    .valid_o(sq_v),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // stage 4: numerators -b +/- s, divider operands
  coef_t c4_x;
  logic signed [W+2:0] nb, s_x, nump, numm, magp, magm;
  logic [NUM_W-1:0] num0_q, num1_q;
  logic [DEN_W-1:0] den0_q, den1_q;
  logic [COEF_W:0]  side0_q;
  logic             neg1_q;
  logic             neg0, neg1;
  logic             lin;
  always_comb begin
    c4_x = coef_t'(sq_side);
    nb   = c4_x.bn ? (W+3)'(c4_x.bm) : -(W+3)'(c4_x.bm);
    s_x  = (W+3)'(sq_root);
    nump = nb + s_x;
    numm = nb - s_x;
    magp = nump[W+2] ? -nump : nump;
    magm = numm[W+2] ? -numm : numm;
    lin  = (c4_x.st == ST_LINEAR);
    neg0 = lin ? ((c4_x.cm != '0) && (c4_x.cn == c4_x.bn))
               : ((magp[W:0] != '0) && (nump[W+2] != c4_x.an));
    neg1 = (magm[W:0] != '0) && (numm[W+2] != c4_x.an);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      num0_q  <= lin ? {1'b0, c4_x.cm, {F{1'b0}}} : {magp[W:0], {F{1'b0}}};
      den0_q  <= lin ? {1'b0, c4_x.bm} : {c4_x.am, 1'b0};
      num1_q  <= {magm[W:0], {F{1'b0}}};
      den1_q  <= {c4_x.am, 1'b0};
      side0_q <= {c4_x, neg0};
      neg1_q  <= neg1;
    end
  end

  logic             d0_v, d1_v;
  logic [NUM_W-1:0] q0, q1;
  logic [COEF_W:0]  d0_side;
  logic             d1_side;

  qrs_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .SIDE_W(COEF_W + 1)
  ) u_div_plus (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v4_q),
    .num_i  (num0_q),
    .den_i  (den0_q),
    .side_i (side0_q),
    .valid_o(d0_v),
    .quo_o  (q0),
    .side_o (d0_side)
  );

  qrs_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .SIDE_W(1)
  ) u_div_minus (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v4_q),
    .num_i  (num1_q),
    .den_i  (den1_q),
    .side_i (neg1_q),
    .valid_o(d1_v),
    .quo_o  (q1),
    .side_o (d1_side)
  );

  // stage 5: saturate roots
  coef_t c5_x, c5_q;
  logic [W-1:0] xmp_d, xmm_d;
  logic [W-1:0] xmp_q, xmm_q;
  logic         xnp_q, xnm_q;
  logic [W-1:0] rp5_q, rm5_q;
  always_comb begin
    c5_x  = coef_t'(d0_side[COEF_W:1]);
    xmp_d = sat_mag(d0_side[0], q0);
    xmm_d = sat_mag(d1_side, q1);
    if (c5_x.st == ST_NONE || c5_x.st == ST_DEGEN) begin
      xmp_d = '0;
      xmm_d = '0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      c5_q  <= c5_x;
      xmp_q <= xmp_d;
      xmm_q <= xmm_d;
      xnp_q <= d0_side[0];
      xnm_q <= d1_side;
      rp5_q <= d0_side[0] ? -xmp_d : xmp_d;
      if (c5_x.st == ST_LINEAR) begin
        rm5_q <= d0_side[0] ? -xmp_d : xmp_d;
      end else begin
        rm5_q <= d1_side ? -xmm_d : xmm_d;
      end
    end
  end

  // stage 6: a*x
  coef_t c6_q;
  logic [W-1:0]   rp6_q, rm6_q, xmp6_q, xmm6_q;
  logic [2*W-1:0] pp_q, pm_q;
  logic           tnp_q, tnm_q, xnp6_q, xnm6_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c6_q   <= c5_q;
      rp6_q  <= rp5_q;
      rm6_q  <= rm5_q;
      xmp6_q <= xmp_q;
      xmm6_q <= xmm_q;
      xnp6_q <= xnp_q;
      xnm6_q <= xnm_q;
      pp_q   <= c5_q.am * xmp_q;
      pm_q   <= c5_q.am * xmm_q;
      tnp_q  <= c5_q.an ^ xnp_q;
      tnm_q  <= c5_q.an ^ xnm_q;
    end
  end

  // stage 7: (a*x >> F) + b, clamped
  logic [MX-1:0] lim;
  logic [MX-1:0] bv, tvp, tvm, sump, summ, amp, amm;
  always_comb begin
    lim  = MX'(1) << (W + 1 + F);
    bv   = MX'(c6_q.bm);
    tvp  = MX'(pp_q[2*W-1:F]);
    tvm  = MX'(pm_q[2*W-1:F]);
    sump = (tnp_q ? -tvp : tvp) + (c6_q.bn ? -bv : bv);
    summ = (tnm_q ? -tvm : tvm) + (c6_q.bn ? -bv : bv);
    amp  = sump[MX-1] ? -sump : sump;
    amm  = summ[MX-1] ? -summ : summ;
    if (amp > lim) amp = lim;
    if (amm > lim) amm = lim;
  end

  coef_t c7_q;
  logic [W-1:0]  rp7_q, rm7_q, xmp7_q, xmm7_q;
  logic [CW-1:0] tmp_q, tmm_q;
  logic          vnp_q, vnm_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c7_q   <= c6_q;
      rp7_q  <= rp6_q;
      rm7_q  <= rm6_q;
      xmp7_q <= xmp6_q;
      xmm7_q <= xmm6_q;
      tmp_q  <= amp[CW-1:0];
      tmm_q  <= amm[CW-1:0];
      vnp_q  <= sump[MX-1] ^ xnp6_q;
      vnm_q  <= summ[MX-1] ^ xnm6_q;
    end
  end

  // stage 8: t*x as two partial products, low and high half of t
  coef_t c8_q;
  logic [W-1:0]      rp8_q, rm8_q;
  logic [LO_W+W-1:0] plp_q, plm_q;
  logic [HI_W+W-1:0] php_q, phm_q;
  logic              vnp8_q, vnm8_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c8_q   <= c7_q;
      rp8_q  <= rp7_q;
      rm8_q  <= rm7_q;
      plp_q  <= tmp_q[LO_W-1:0] * xmp7_q;
      php_q  <= tmp_q[CW-1:LO_W] * xmp7_q;
      plm_q  <= tmm_q[LO_W-1:0] * xmm7_q;
      phm_q  <= tmm_q[CW-1:LO_W] * xmm7_q;
      vnp8_q <= vnp_q;
      vnm8_q <= vnm_q;
    end
  end

  // stage 8b: sum the partial products
  coef_t c8b_q;
  logic [W-1:0]  rp8b_q, rm8b_q;
  logic [PW-1:0] p2p_q, p2m_q;
  logic          vnp8b_q, vnm8b_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c8b_q   <= c8_q;
      rp8b_q  <= rp8_q;
      rm8b_q  <= rm8_q;
      p2p_q   <= PW'(plp_q) + (PW'(php_q) << LO_W);
      p2m_q   <= PW'(plm_q) + (PW'(phm_q) << LO_W);
      vnp8b_q <= vnp8_q;
      vnm8b_q <= vnm8_q;
    end
  end

  // stage 9: (t*x >> F) + c against the tolerance
  logic [VX-1:0] cv, vvp, vvm, rsp, rsm, rmp, rmm;
  always_comb begin
    cv  = VX'(c8b_q.cm);
    vvp = VX'(p2p_q[PW-1:F]);
    vvm = VX'(p2m_q[PW-1:F]);
    rsp = (vnp8b_q ? -vvp : vvp) + (c8b_q.cn ? -cv : cv);
    rsm = (vnm8b_q ? -vvm : vvm) + (c8b_q.cn ? -cv : cv);
    rmp = rsp[VX-1] ? -rsp : rsp;
    rmm = rsm[VX-1] ? -rsm : rsm;
  end

  coef_t c9_q;
  logic [W-1:0] rp9_q, rm9_q;
  logic         ok_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c9_q  <= c8b_q;
      rp9_q <= rp8b_q;
      rm9_q <= rm8b_q;
      ok_q  <= (rmp <= VX'(tol_q)) && (rmm <= VX'(tol_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v8b_q <= 1'b0;
      v9_q  <= 1'b0;
    end else if (en) begin
      v1_q  <= in_valid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= sq_v;
      v5_q  <= d0_v && d1_v;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v8b_q <= v8_q;
      v9_q  <= v8b_q;
    end
  end

  // output register; the pipe may still move while it holds a stalled result
  logic           out_valid_q;
  status_e        status_q;
  logic [W-1:0]   rp_q, rm_q;

  assign out_ld     = !out_valid_q || !out_stall_i;
  assign en         = out_ld || !v9_q;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      status_q <= (c9_q.st == ST_TWO && !ok_q) ? ST_CHECK : c9_q.st;
      rp_q     <= rp9_q;
      rm_q     <= rm9_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign root_plus_o  = rp_q;
  assign root_minus_o = rm_q;

endmodule

// ===== sv/qrs_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module qrs_sqrt #(
  parameter int ROOT_W = 33,
  parameter int SIDE_W = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [2*ROOT_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic [ROOT_W-1:0]     root_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int REM_W = ROOT_W + 2;
  localparam int T_W   = ROOT_W + 4;

  logic [ROOT_W-1:0]   valid_q;
  logic [REM_W-1:0]    rem_q  [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];
  logic [2*ROOT_W-1:0] rad_q  [ROOT_W];
  logic [SIDE_W-1:0]   side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic                valid_in;
    logic [REM_W-1:0]    rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [2*ROOT_W-1:0] rad_in;
    logic [SIDE_W-1:0]   side_in;
    logic [T_W-1:0]      t;
    logic [T_W-1:0]      trial;
    logic                ge;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = '0;
      assign root_in  = '0;
      assign rad_in   = rad_i;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign root_in  = root_q[k-1];
      assign rad_in   = rad_q[k-1];
      assign side_in  = side_q[k-1];
    end

    assign t     = {rem_in, rad_in[2*ROOT_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? REM_W'(t - trial) : REM_W'(t);
        root_q[k] <= {root_in[ROOT_W-2:0], ge};
        rad_q[k]  <= {rad_in[2*ROOT_W-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

// ===== sv/qrs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module qrs_div #(
  parameter int NUM_W  = 49,
  parameter int DEN_W  = 33,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [NUM_W-1:0]  valid_q;
  logic [DEN_W-1:0]  rem_q  [NUM_W];
  logic [NUM_W-1:0]  numq_q [NUM_W];
  logic [DEN_W-1:0]  den_q  [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              valid_in;
    logic [DEN_W-1:0]  rem_in;
    logic [NUM_W-1:0]  numq_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    t;
    logic              ge;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = '0;
      assign numq_in  = num_i;
      assign den_in   = den_i;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign numq_in  = numq_q[k-1];
      assign den_in   = den_q[k-1];
      assign side_in  = side_q[k-1];
    end

    assign t  = {rem_in, numq_in[NUM_W-1]};
    assign ge = (t >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end

    // quotient bits shift in at the bottom as numerator bits leave the top
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? DEN_W'(t - {1'b0, den_in}) : DEN_W'(t);
        numq_q[k] <= {numq_in[NUM_W-2:0], ge};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[NUM_W-1];
  assign quo_o   = numq_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];

endmodule

// ===== sv/qrs_checker.sv =====
`include "quadratic_root_solver_defines.svh"

module qrs_checker
  import qrs_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [STATUS_W-1:0]   status_o,
  input logic [DATA_WIDTH-1:0] root_plus_o,
  input logic [DATA_WIDTH-1:0] root_minus_o
);

  `QRS_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o) && $stable(root_plus_o) && $stable(root_minus_o)), "stalled result changed")

  `QRS_ASSERT(a_no_root_zero, (out_valid_o && (status_o == ST_NONE || status_o == ST_DEGEN)) |-> (root_plus_o == '0 && root_minus_o == '0), "roots not zero without real roots")

  `QRS_ASSERT(a_linear_same, (out_valid_o && status_o == ST_LINEAR) |-> (root_plus_o == root_minus_o), "linear roots differ")

  `QRS_ASSERT_ALWAYS(a_stall_cause, (in_stall_o && in_valid_i) |-> (out_valid_o && out_stall_i), "input stalled with output free")

endmodule

bind quadratic_root_solver qrs_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qrs_checker (.*);

// ===== verif/quadratic_root_solver_tb.sv =====
module quadratic_root_solver_tb;
  import qrs_pkg::*;

  localparam int FB = 16;
  localparam int DW = 32;
  localparam int LATENCY = 2 * DW + FB + 13;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef logic [127:0] wide_t;
  typedef struct packed {
    bit    neg;
    wide_t mag;
  } smag_t;
  typedef struct {
    status_e            status;
    logic signed [31:0] root_plus;
    logic signed [31:0] root_minus;
  } roots_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [TOL_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [DW-1:0] coeff_a_i = '0, coeff_b_i = '0, coeff_c_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic signed [DW-1:0] root_plus_o, root_minus_o;

  quadratic_root_solver u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .coeff_a_i    (coeff_a_i),
    .coeff_b_i    (coeff_b_i),
    .coeff_c_i    (coeff_c_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .root_plus_o  (root_plus_o),
    .root_minus_o (root_minus_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [TOL_W-1:0] tol_model = TOL_RESET;
  roots_t pending_roots[$];
  int errors = 0;
  int quiet_cycles = 0;
  bit idle_en = 1'b1;

  // ---------------- predictor ----------------
  function automatic smag_t signed_add(smag_t x, smag_t y);
    smag_t r;
    if (x.neg == y.neg) begin
      r.neg = x.neg; r.mag = x.mag + y.mag;
    end else if (x.mag >= y.mag) begin
      r.neg = x.neg; r.mag = x.mag - y.mag;
    end else begin
      r.neg = y.neg; r.mag = y.mag - x.mag;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_q(bit neg, wide_t m);
    if (neg) return (m >= 128'h8000_0000) ? 32'sh8000_0000 : -m[31:0];
    return (m > 128'h7fff_ffff) ? 32'sh7fff_ffff : m[31:0];
  endfunction

  function automatic wide_t isqrt(wide_t v);
    wide_t r, cand;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      cand = r | (wide_t'(1) << k);
      if (cand * cand <= v) r = cand;
    end
    return r;
  endfunction

  // substitute a root back; true when the residual is within tolerance
  function automatic bit residual_ok(bit an, wide_t am, bit bn, wide_t bm,
                                     bit cn, wide_t cm, logic signed [31:0] x);
    longint xl;
    wide_t xm;
    smag_t t, v, bterm, cterm;
    xl = x;
    xm = (xl < 0) ? wide_t'(-xl) : wide_t'(xl);
    t.neg = an != (xl < 0);
    t.mag = (am * xm) >> FB;
    bterm.neg = bn; bterm.mag = bm;
    t = signed_add(t, bterm);
    if (t.mag > (wide_t'(1) << (DW + 1 + FB))) t.mag = wide_t'(1) << (DW + 1 + FB);
    v.neg = t.neg != (xl < 0);
    v.mag = (t.mag * xm) >> FB;
    cterm.neg = cn; cterm.mag = cm;
    v = signed_add(v, cterm);
    return v.mag <= wide_t'(tol_model);
  endfunction

  function automatic roots_t solve_roots(logic signed [31:0] a, logic signed [31:0] b,
                                         logic signed [31:0] c);
    roots_t res;
    bit an, bn, cn, nn;
    wide_t am, bm, cm, sq, ac4, disc, s, nm;
    longint nb, num;
    logic signed [31:0] rt[2];
    an = a[31]; bn = b[31]; cn = c[31];
    am = an ? wide_t'(-longint'(a)) : wide_t'(a);
    bm = bn ? wide_t'(-longint'(b)) : wide_t'(b);
    cm = cn ? wide_t'(-longint'(c)) : wide_t'(c);
    res.root_plus = '0;
    res.root_minus = '0;
    if (am == 0) begin
      if (bm == 0) begin
        res.status = ST_DEGEN;
      end else begin
        res.root_plus = clamp_q(cm != 0 && cn == bn, (cm << FB) / bm);
        res.root_minus = res.root_plus;
        res.status = ST_LINEAR;
      end
      return res;
    end
    sq = bm * bm;
    ac4 = (am * cm) << 2;
    if (an != cn) begin
      disc = sq + ac4;
    end else if (sq < ac4) begin
      res.status = ST_NONE;
      return res;
    end else begin
      disc = sq - ac4;
    end
    s = isqrt(disc);
    nb = bn ? longint'(bm) : -longint'(bm);
    for (int k = 0; k < 2; k++) begin
      num = (k == 0) ? nb + longint'(s) : nb - longint'(s);
      nn = num < 0;
      nm = nn ? wide_t'(-num) : wide_t'(num);
      rt[k] = clamp_q(nm != 0 && nn != an, (nm << FB) / (am << 1));
    end
    res.root_plus = rt[0];
    res.root_minus = rt[1];
    res.status = (residual_ok(an, am, bn, bm, cn, cm, rt[0]) &&
                  residual_ok(an, am, bn, bm, cn, cm, rt[1])) ? ST_TWO : ST_CHECK;
    return res;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_request(logic signed [31:0] a, logic signed [31:0] b,
                              logic signed [31:0] c);
    int gap;
    if (idle_en && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    coeff_a_i = a;
    coeff_b_i = b;
    coeff_c_i = c;
    do @(posedge clk_i); while (in_stall_o);
    pending_roots.push_back(solve_roots(a, b, c));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_roots.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] tol);
    drain();
    repeat (LATENCY) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = tol;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    tol_model = tol;
  endtask

  int stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(4) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------- result check ----------------
  always @(posedge clk_i) begin
    roots_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_roots.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        exp_r = pending_roots.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, status_o);
          errors++;
        end
        if (root_plus_o !== exp_r.root_plus) begin
          $error("root_plus expected %h actual %h", exp_r.root_plus, root_plus_o);
          errors++;
        end
        if (root_minus_o !== exp_r.root_minus) begin
          $error("root_minus expected %h actual %h", exp_r.root_minus, root_minus_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------- tests ----------------
  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;

  task automatic test_special_cases();
    send_request(0, 0, 0);               // degenerate
    send_request(0, 0, MAXV);
    send_request(0, 2 * ONE, -4 * ONE);  // linear
    send_request(0, MINV, MINV);
    send_request(0, 1, MAXV);            // linear saturates
    send_request(0, -1, MAXV);
    send_request(ONE, 0, ONE);           // no real roots
    send_request(ONE, -3 * ONE, 2 * ONE);
    send_request(-ONE, 0, 4 * ONE);
    send_request(ONE, 2 * ONE, ONE);     // double root
    send_request(ONE, 0, -2 * ONE);      // irrational, check may fail
    send_request(1, MAXV, 0);            // roots saturate
    send_request(MAXV, MAXV, MAXV);
    send_request(MINV, MINV, MINV);
    send_request(MINV, MAXV, MAXV);
    send_request(MAXV, MINV, MINV);
    send_request(-1, -1, -1);
    send_request(1, 0, MINV);
    send_request(3 * ONE, 5 * ONE, -7 * ONE);
    send_request(ONE, 0, 0);
  endtask

  task automatic test_tolerance_extremes();
    write_tolerance(0);
    send_request(ONE, -3 * ONE, 2 * ONE);
    send_request(ONE, 0, -2 * ONE);
    send_request(3 * ONE, ONE, -ONE);
    write_tolerance(16'hffff);
    send_request(ONE, 0, -2 * ONE);
    send_request(3 * ONE, ONE, -ONE);
    send_request(MAXV, MINV, MINV);
  endtask

  task automatic test_random(int count);
    logic signed [31:0] a, b, c, r1, r2;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(5))
        0: begin
          a = $urandom; b = $urandom; c = $urandom;
        end
        1: begin
          a = 0; b = ($urandom_range(7) == 0) ? 0 : $signed($urandom);
          c = $urandom;
        end
        2, 3: begin
          // well-formed: integer-ish roots times a small leading coefficient
          r1 = $signed($urandom_range(0, 64)) - 32;
          r2 = $signed($urandom_range(0, 64)) - 32;
          a = $signed($urandom_range(1, 8)) * ($urandom_range(1) ? 1 : -1);
          b = -a * (r1 + r2) * ONE;
          c = a * r1 * r2 * ONE;
          a = a * ONE;
        end
        default: begin
          a = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
          b = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
          c = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
        end
      endcase
      send_request(a, b, c);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_special_cases();
    test_tolerance_extremes();
    write_tolerance(TOL_RESET);
    test_random(200);
    write_tolerance($urandom_range(0, 65535));
    test_random(200);
    write_tolerance(16'd1);
    test_random(100);
    idle_en = 1'b0;
    test_random(100);
    drain();
    repeat (LATENCY + 20) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
